// File: rtl/aluf_pkg.sv
// ----------------------------------------------------------------------------
// aluf_pkg
// Shared types, opcodes and flag positions for the pipelined 16-bit ALU.
// ----------------------------------------------------------------------------
package aluf_pkg;

  localparam int DataWidth = 16;
  localparam int OpWidth   = 8;
  localparam int FlagWidth = 8;

  // Divider: quotient bits resolved per pipeline stage.
  localparam int DivBits   = 2;
  localparam int DivStages = DataWidth / DivBits;

  localparam logic [OpWidth-1:0] OpAdd = 8'h01;
  localparam logic [OpWidth-1:0] OpSub = 8'h02;
  localparam logic [OpWidth-1:0] OpMul = 8'h03;
  localparam logic [OpWidth-1:0] OpDiv = 8'h04;
  localparam logic [OpWidth-1:0] OpAnd = 8'h05;
  localparam logic [OpWidth-1:0] OpOr  = 8'h06;
  localparam logic [OpWidth-1:0] OpXor = 8'h07;
  localparam logic [OpWidth-1:0] OpNot = 8'h08;
  localparam logic [OpWidth-1:0] OpInc = 8'h09;
  localparam logic [OpWidth-1:0] OpCmp = 8'h0A;
  localparam logic [OpWidth-1:0] OpDec = 8'h0B;

  localparam int FlagZ = 0;
  localparam int FlagL = 1;
  localparam int FlagG = 2;

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [FlagWidth-1:0] flags_t;

  typedef struct packed {
    logic [OpWidth-1:0] op;
    word_t              a;
    word_t              b;
    flags_t             flags;
  } req_t;

  typedef struct packed {
    logic   valued;
    logic   is_div;
    word_t  b;
    flags_t flags;
    word_t  res;
    word_t  rem;
    word_t  quo;
  } pipe_t;

endpackage

// File: rtl/aluf_exec.sv
// ----------------------------------------------------------------------------
// aluf_exec
// Single-stage operations, compare flags and divider setup for one request.
// ----------------------------------------------------------------------------
module aluf_exec (
  input  aluf_pkg::req_t  req_i,
  output aluf_pkg::pipe_t pipe_o
);

  logic [2*aluf_pkg::DataWidth-1:0] prod;

  assign prod = {{aluf_pkg::DataWidth{1'b0}}, req_i.a} * {{aluf_pkg::DataWidth{1'b0}}, req_i.b};

  always_comb begin
    pipe_o        = '0;
    pipe_o.valued = 1'b1;
    pipe_o.is_div = 1'b0;
    pipe_o.b      = req_i.b;
    pipe_o.flags  = req_i.flags;
    pipe_o.res    = '0;
    pipe_o.rem    = '0;
    pipe_o.quo    = req_i.a;
    case (req_i.op)
      aluf_pkg::OpAdd: pipe_o.res = aluf_pkg::word_t'(req_i.a + req_i.b);
      aluf_pkg::OpSub: pipe_o.res = aluf_pkg::word_t'(req_i.a - req_i.b);
      aluf_pkg::OpMul: pipe_o.res = prod[aluf_pkg::DataWidth-1:0];
      aluf_pkg::OpDiv: pipe_o.is_div = 1'b1;
      aluf_pkg::OpAnd: pipe_o.res = req_i.a & req_i.b;
      aluf_pkg::OpOr:  pipe_o.res = req_i.a | req_i.b;
      aluf_pkg::OpXor: pipe_o.res = req_i.a ^ req_i.b;
      aluf_pkg::OpNot: pipe_o.res = ~req_i.a;
      aluf_pkg::OpInc: pipe_o.res = aluf_pkg::word_t'(req_i.a + aluf_pkg::word_t'(1));
      aluf_pkg::OpDec: pipe_o.res = aluf_pkg::word_t'(req_i.a - aluf_pkg::word_t'(1));
      aluf_pkg::OpCmp: begin
        pipe_o.valued                   = 1'b0;
        pipe_o.flags[aluf_pkg::FlagZ]   = (req_i.a == req_i.b);
        pipe_o.flags[aluf_pkg::FlagL]   = (req_i.a < req_i.b);
        pipe_o.flags[aluf_pkg::FlagG]   = (req_i.a > req_i.b);
      end
      default: pipe_o.valued = 1'b0;
    endcase
  end

endmodule

// File: rtl/aluf_div_step.sv
// ----------------------------------------------------------------------------
// aluf_div_step
// Restoring unsigned division, DivBits quotient bits per pipeline stage.
// ----------------------------------------------------------------------------
module aluf_div_step (
  input  aluf_pkg::pipe_t pipe_i,
  output aluf_pkg::pipe_t pipe_o
);

  always_comb begin
    logic [aluf_pkg::DataWidth:0] trial;
    aluf_pkg::word_t              rem;
    aluf_pkg::word_t              quo;
    trial = '0;
    rem   = pipe_i.rem;
    quo   = pipe_i.quo;
    for (int i = 0; i < aluf_pkg::DivBits; i++) begin
      trial = {rem, quo[aluf_pkg::DataWidth-1]};
      quo   = {quo[aluf_pkg::DataWidth-2:0], 1'b0};
      if (trial >= {1'b0, pipe_i.b}) begin
        trial  = trial - {1'b0, pipe_i.b};
        quo[0] = 1'b1;
      end
      rem = trial[aluf_pkg::DataWidth-1:0];
    end
    pipe_o     = pipe_i;
    pipe_o.rem = rem;
    pipe_o.quo = quo;
  end

endmodule

// File: rtl/alu16_with_compare_flags.sv
// ----------------------------------------------------------------------------
// alu16_with_compare_flags
// Pipelined 16-bit ALU with zero/less/greater flag update.
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_stall_o is low; each result appears once its
// request has passed one input register, eight divider stages and one output register.
// Every opcode takes this same path, whose length is set by the divider, which
// resolves two quotient bits per stage. Each stage holds its request while the
// next one is full and stalled, so bubbles close up and the input keeps taking
// requests while a finished result waits at the output, until every stage is full.
// ----------------------------------------------------------------------------
module alu16_with_compare_flags (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [aluf_pkg::OpWidth-1:0]       action_i,
  input  logic [aluf_pkg::DataWidth-1:0]     operand_a_i,
  input  logic [aluf_pkg::DataWidth-1:0]     operand_b_i,
  input  logic [aluf_pkg::FlagWidth-1:0]     flags_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [aluf_pkg::DataWidth-1:0]     result_o,
  output logic [aluf_pkg::FlagWidth-1:0]     flags_out_o
);

  aluf_pkg::req_t  req_q;
  logic            req_valid_q;
  aluf_pkg::pipe_t exec_pipe;
  aluf_pkg::pipe_t pipe_q [1:aluf_pkg::DivStages];
  aluf_pkg::pipe_t pipe_d [1:aluf_pkg::DivStages];
  logic [aluf_pkg::DivStages:1]   valid_q;
  logic [aluf_pkg::DivStages+1:0] rdy;

  aluf_pkg::word_t  result_d, result_q;
  aluf_pkg::flags_t flags_d, flags_q;
  logic             out_valid_q;

  // Ready chain: a stage takes new data when empty or when it drains.
  assign rdy[aluf_pkg::DivStages+1] = !out_valid_q || !out_stall_i;
  assign rdy[0] = !req_valid_q || rdy[1];

  for (genvar k = 1; k <= aluf_pkg::DivStages; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end

  assign in_stall_o = !rdy[0];

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (rdy[0]) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      req_q <= '{op: action_i, a: operand_a_i, b: operand_b_i, flags: flags_in_i};
    end
  end

  aluf_exec u_exec (
    .req_i  (req_q),
    .pipe_o (exec_pipe)
  );

  // Divider pipeline; other ops ride along.
  for (genvar k = 1; k <= aluf_pkg::DivStages; k++) begin : g_stage
    if (k == 1) begin : g_first
      aluf_div_step u_step (
        .pipe_i (exec_pipe),
        .pipe_o (pipe_d[k])
      );

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          valid_q[k] <= req_valid_q;
        end
      end
    end else begin : g_next
      aluf_div_step u_step (
        .pipe_i (pipe_q[k-1]),
        .pipe_o (pipe_d[k])
      );

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // Result select and flag update
  always_comb begin
    aluf_pkg::pipe_t p;
    p        = pipe_q[aluf_pkg::DivStages];
    result_d = p.res;
    if (p.is_div) begin
      result_d = (p.b == '0) ? '0 : p.quo;
    end
    flags_d = p.flags;
    if (p.valued) begin
      if (result_d == '0) begin
        flags_d[aluf_pkg::FlagZ] = 1'b1;
        flags_d[aluf_pkg::FlagL] = 1'b0;
        flags_d[aluf_pkg::FlagG] = 1'b0;
      end else begin
        flags_d[aluf_pkg::FlagZ] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[aluf_pkg::DivStages+1]) begin
      out_valid_q <= valid_q[aluf_pkg::DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[aluf_pkg::DivStages+1]) begin
      result_q <= result_d;
      flags_q  <= flags_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign flags_out_o = flags_q;

  // Assertions
  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> req_valid_q)
    else $error("accepted request not held in input stage");

  a_last_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[aluf_pkg::DivStages] && rdy[aluf_pkg::DivStages+1]) |=> out_valid_q)
    else $error("result lost between divider and output");

  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[aluf_pkg::DivStages] && !rdy[aluf_pkg::DivStages+1]) |=>
      (valid_q[aluf_pkg::DivStages] && $stable(pipe_q[aluf_pkg::DivStages])))
    else $error("last divider stage changed while blocked");

endmodule
